// ===== sv/kvmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvmt_pkg
// Shared types, codes and constants of the key/value map table.
// ----------------------------------------------------------------------------
package kvmt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int ENTRY_W      = 1 + KEY_W + VAL_W;

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_GET    = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic sweep_wr;
        logic finish;
    } kvmt_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic cnt_done;
    } kvmt_stat_t;

    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage : kvmt_pkg
`default_nettype wire

// ===== sv/kvmt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvmt_ram
    import kvmt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = idx_w(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : kvmt_ram
`default_nettype wire

// ===== sv/kvmt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvmt_ctrl
// Sequencer: initial clearing sweep, command decode, table scan and finish.
// ----------------------------------------------------------------------------
module kvmt_ctrl
    import kvmt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] cmd,
    input  wire kvmt_stat_t stat,
    output kvmt_cmd_t       ctl,
    output logic            busy
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CLEAR  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.sweep_wr = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = (cmd == CMD_CLEAR) ? S_CLEAR : S_SCAN;
                end
            end
            S_CLEAR:
            begin
                ctl.sweep_wr = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                ctl.scan_rd = !stat.cnt_done;
                if (stat.cnt_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule : kvmt_ctrl
`default_nettype wire

// ===== sv/kvmt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvmt_dp
// Datapath: request registers, entry table, scan counter, key compare and
// result registers.
// ----------------------------------------------------------------------------
module kvmt_dp
    import kvmt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kvmt_cmd_t          ctl,
    output kvmt_stat_t              stat,
    input  wire logic        [1:0]  cmd,
    input  wire logic signed [31:0] req_key,
    input  wire logic signed [31:0] req_value,
    output logic                    done,
    output logic signed      [31:0] read_value,
    output logic             [1:0]  status
);

    localparam int AW = idx_w(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(CAPACITY - 1);
    localparam logic [CW-1:0] CNT_DONE = CW'(CAPACITY);

    logic [1:0]       cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    logic [CW-1:0] cnt_reg;
    logic          rd_pend_reg;
    logic [AW-1:0] rd_idx_reg;

    logic             hit_reg;
    logic [AW-1:0]    hit_idx_reg;
    logic [VAL_W-1:0] hit_val_reg;
    logic             free_reg;
    logic [AW-1:0]    free_idx_reg;

    logic             done_reg;
    logic [VAL_W-1:0] rd_val_reg;
    logic [1:0]       status_reg;
    logic [VAL_W-1:0] rd_val_next;
    logic [1:0]       status_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic             ent_valid;
    logic [KEY_W-1:0] ent_key;
    logic [VAL_W-1:0] ent_val;

    assign ent_valid = ram_rdata[ENTRY_W-1];
    assign ent_key   = ram_rdata[KEY_W+VAL_W-1:VAL_W];
    assign ent_val   = ram_rdata[VAL_W-1:0];

    assign stat.cnt_last = (cnt_reg == CNT_LAST);
    assign stat.cnt_done = (cnt_reg == CNT_DONE);

    // request capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            key_reg <= req_key;
            val_reg <= req_value;
        end
    end

    // scan counter and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                cnt_reg <= '0;
            end
            else if (ctl.scan_rd || ctl.sweep_wr)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_pend_reg <= ctl.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[AW-1:0];
    end

    // match and free slot search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (rd_pend_reg)
        begin
            if (ent_valid && (ent_key == key_reg) && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!ent_valid && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            if (ent_valid && (ent_key == key_reg) && !hit_reg)
            begin
                hit_idx_reg <= rd_idx_reg;
                hit_val_reg <= ent_val;
            end
            if (!ent_valid && !free_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    // table write: clearing sweep or finishing update
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = hit_reg ? hit_idx_reg : free_idx_reg;
        ram_wdata = '0;
        if (ctl.sweep_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[AW-1:0];
        end
        else if (ctl.finish)
        begin
            case (cmd_reg)
                CMD_PUT:
                begin
                    ram_we    = hit_reg || free_reg;
                    ram_wdata = {1'b1, key_reg, val_reg};
                end
                CMD_REMOVE:
                begin
                    ram_we = hit_reg;
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    kvmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.scan_rd),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // result
    always_comb
    begin
        rd_val_next = '0;
        status_next = ST_DONE;
        case (cmd_reg)
            CMD_PUT:
            begin
                status_next = (hit_reg || free_reg) ? ST_DONE : ST_FULL;
            end
            CMD_REMOVE:
            begin
                status_next = hit_reg ? ST_DONE : ST_NOT_FOUND;
            end
            CMD_GET:
            begin
                rd_val_next = hit_reg ? hit_val_reg : '1;
                status_next = hit_reg ? ST_DONE : ST_NOT_FOUND;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            rd_val_reg <= rd_val_next;
            status_reg <= status_next;
        end
    end

    assign done       = done_reg;
    assign read_value = rd_val_reg;
    assign status     = status_reg;

endmodule : kvmt_dp
`default_nettype wire

// ===== sv/key_value_map_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_map_table
// Bounded key/value map with unique keys held in a scanned entry table.
// ----------------------------------------------------------------------------
// A request (cmd, req_key, req_value) is taken when start is high and busy
// is low. put, remove and get scan all CAPACITY entries of the table RAM,
// one per cycle, before the done strobe; clear instead writes every entry
// back to invalid and then gives its done strobe. The result
// (read_value, status) is shown for exactly one cycle with done high and
// must be taken then: there is no stall from the receiver. A new request
// may be issued in the cycle done is high. After reset the table is swept
// clear, with busy high, before the first request.
// ----------------------------------------------------------------------------
module key_value_map_table
    import kvmt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  cmd,
    input  wire logic signed [31:0] req_key,
    input  wire logic signed [31:0] req_value,
    output logic                    done,
    output logic signed      [31:0] read_value,
    output logic             [1:0]  status
);

    kvmt_cmd_t  ctl;
    kvmt_stat_t stat;

    kvmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    kvmt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .req_key    (req_key),
        .req_value  (req_value),
        .done       (done),
        .read_value (read_value),
        .status     (status)
    );

endmodule : key_value_map_table
`default_nettype wire
